// ===== design/fpcp_pkg.sv =====
package fpcp_pkg;

	localparam int YAW_FULL = 25736;
	localparam int PITCH_LIMIT = 5361;
	localparam logic signed [34:0] PI_Q24 = 35'sd52707179;
	localparam logic signed [34:0] HALF_PI_Q24 = 35'sd26353589;
	localparam logic signed [34:0] TWO_PI_Q24 = 35'sd105414357;
	localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

	typedef enum logic [1:0] {
		KIND_STRIDE = 2'd0,
		KIND_STRAFE = 2'd1,
		KIND_CLIMB  = 2'd2,
		KIND_LOOK   = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		CFG_LOOK_GAIN  = 1'd0,
		CFG_ROLL_ANGLE = 1'd1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROT,
		ST_DONE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_M7,
		ST_OUT
	} state_t;

	function automatic logic signed [34:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0:  atan_q24 = 35'sd13176795;
			5'd1:  atan_q24 = 35'sd7778716;
			5'd2:  atan_q24 = 35'sd4110060;
			5'd3:  atan_q24 = 35'sd2086331;
			5'd4:  atan_q24 = 35'sd1047214;
			5'd5:  atan_q24 = 35'sd524117;
			5'd6:  atan_q24 = 35'sd262123;
			5'd7:  atan_q24 = 35'sd131069;
			5'd8:  atan_q24 = 35'sd65536;
			5'd9:  atan_q24 = 35'sd32768;
			5'd10: atan_q24 = 35'sd16384;
			5'd11: atan_q24 = 35'sd8192;
			5'd12: atan_q24 = 35'sd4096;
			5'd13: atan_q24 = 35'sd2048;
			5'd14: atan_q24 = 35'sd1024;
			5'd15: atan_q24 = 35'sd512;
			5'd16: atan_q24 = 35'sd256;
			5'd17: atan_q24 = 35'sd128;
			5'd18: atan_q24 = 35'sd64;
			5'd19: atan_q24 = 35'sd32;
			5'd20: atan_q24 = 35'sd16;
			5'd21: atan_q24 = 35'sd8;
			5'd22: atan_q24 = 35'sd4;
			5'd23: atan_q24 = 35'sd2;
			default: atan_q24 = 35'sd0;
		endcase
	endfunction

endpackage

// ===== design/fpcp_cordic.sv =====
module fpcp_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  angle,
	output logic                done,
	output logic signed [15:0]  sin_q14,
	output logic signed [15:0]  cos_q14
);
	import fpcp_pkg::*;

	localparam int SW = $clog2(CORDIC_STEPS + 1);

	logic signed [34:0] z_q;
	logic signed [35:0] x_q, y_q;
	logic               flip_q;
	logic [SW-1:0]      step_q;
	logic               busy_q;
	logic               done_q;

	logic signed [34:0] z0, z1;
	logic               fl;
	logic signed [35:0] xs, ys;
	logic signed [35:0] xf, yf;
	logic signed [35:0] cr, sr;
	logic [4:0]         sidx;

	always_comb begin
		z0 = 35'(angle) <<< 12;
		if (z0 > PI_Q24) begin
			z0 = z0 - TWO_PI_Q24;
		end else if (z0 < -PI_Q24) begin
			z0 = z0 + TWO_PI_Q24;
		end
		fl = 1'b0;
		z1 = z0;
		if (z0 > HALF_PI_Q24) begin
			z1 = z0 - PI_Q24;
			fl = 1'b1;
		end else if (z0 < -HALF_PI_Q24) begin
			z1 = z0 + PI_Q24;
			fl = 1'b1;
		end
	end

	assign sidx = 5'(step_q);
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;
	assign cr = (xf + 36'sd32768) >>> 16;
	assign sr = (yf + 36'sd32768) >>> 16;
	assign cos_q14 = cr[15:0];
	assign sin_q14 = sr[15:0];
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			z_q <= z1;
			flip_q <= fl;
			x_q <= 36'(CORDIC_K_Q30);
			y_q <= '0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q24(sidx);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q24(sidx);
			end
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("cordic done without work");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("cordic busy at done");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q < SW'(CORDIC_STEPS)) else $error("cordic step overrun");
endmodule

// ===== design/first_person_camera_pose_top.sv =====
// Camera pose keeper: each s_tdata transfer is one command (stride, strafe, climb, look) and
// gives one m_tdata transfer with the updated position and angles. One shared CORDIC unit
// computes sine and cosine of pitch, yaw and roll in turn, then one shared 18x32 multiplier
// forms the view or right products, or for look the scaled deltas, in states ST_M0 to ST_M6.
// Climb and look use the same sequence. s_tready is high only while the block is idle; a
// finished result waits in the output register and is taken on m_tready. Config writes take
// effect at once; cfg_ready is always high, so a write during a command can change its result.
module first_person_camera_pose_top #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // amount[31:0], delta_x[47:32], delta_y[63:48]
	input  logic [1:0]   s_tuser,   // kind[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // pos_x, pos_y, pos_z, yaw_out[110:96], pitch_out[124:111]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import fpcp_pkg::*;

	state_t state_q, state_d;
	logic [15:0] gain_q;
	logic signed [15:0] roll_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [14:0] yaw_q;
	logic signed [13:0] pitch_q;
	logic [1:0] kind_q;
	logic signed [31:0] amt_q;
	logic signed [15:0] dx_q, dy_q;
	logic [1:0] which_q;
	logic signed [15:0] sp_q, cp_q, sy_q, cy_q, sr_q, cr_q;
	logic signed [47:0] prod_q;
	logic signed [47:0] acc_q;
	logic signed [15:0] cx_q, cz_q;
	logic [127:0] out_q;
	logic out_v_q;

	logic c_start, c_done;
	logic signed [15:0] c_ang, c_sin, c_cos;
	logic signed [31:0] ma;
	logic signed [17:0] mb;
	logic signed [49:0] mp;
	logic signed [47:0] rnd28;
	logic signed [32:0] sum_x, sum_z, sum_y;
	logic signed [32:0] nyaw, npit;
	logic signed [47:0] dxg, dyg;

	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	always_comb begin
		case (which_q)
			2'd0: c_ang = 16'(pitch_q);
			2'd1: c_ang = 16'($signed({1'b0, yaw_q}));
			default: c_ang = roll_q;
		endcase
	end
	assign c_start = (state_q == ST_LOAD);

	fpcp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(c_start), .angle(c_ang),
		.done(c_done), .sin_q14(c_sin), .cos_q14(c_cos)
	);

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_M0: begin ma = 32'(cp_q); mb = 18'(sy_q); end
			ST_M1: begin ma = 32'(prod_q); mb = 18'(cr_q); end
			ST_M2: begin ma = 32'(sp_q); mb = 18'(sr_q); end
			ST_M3: begin ma = 32'(-cp_q); mb = 18'(cy_q); end
			ST_M4: begin ma = 32'(cy_q); mb = 18'(cr_q); end
			ST_M5: begin
				if (kind_q == KIND_LOOK) begin
					ma = 32'(dx_q);
					mb = 18'($signed({2'b0, gain_q}));
				end else begin
					ma = amt_q;
					mb = 18'(cx_q);
				end
			end
			ST_M6: begin
				if (kind_q == KIND_LOOK) begin
					ma = 32'(dy_q);
					mb = 18'($signed({2'b0, gain_q}));
				end else begin
					ma = amt_q;
					mb = 18'(cz_q);
				end
			end
			default: begin ma = '0; mb = '0; end
		endcase
		mp = ma * mb;
	end

	assign rnd28 = (acc_q - (prod_q <<< 14) + 48'sd134217728) >>> 28;
	assign sum_y = 33'(py_q) + 33'(amt_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid && s_tready) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_ROT;
			ST_ROT: if (c_done) state_d = (which_q == 2'd2) ? ST_DONE : ST_LOAD;
			ST_DONE: state_d = ST_M0;
			ST_M0: state_d = ST_M1;
			ST_M1: state_d = ST_M2;
			ST_M2: state_d = ST_M3;
			ST_M3: state_d = ST_M4;
			ST_M4: state_d = ST_M5;
			ST_M5: state_d = ST_M6;
			ST_M6: state_d = ST_M7;
			ST_M7: state_d = ST_OUT;
			ST_OUT: if (!out_v_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gain_q <= 16'd20;
			roll_q <= '0;
			px_q <= '0;
			py_q <= '0;
			pz_q <= '0;
			yaw_q <= '0;
			pitch_q <= '0;
			out_v_q <= 1'b0;
			which_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LOOK_GAIN: gain_q <= cfg_data;
					CFG_ROLL_ANGLE: roll_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && (!out_v_q || m_tready)) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			if (state_q == ST_IDLE && s_tvalid) which_q <= '0;
			if (state_q == ST_ROT && c_done) which_q <= which_q + 1'b1;
			if (state_q == ST_M7) begin
				case (kind_t'(kind_q))
					KIND_STRIDE, KIND_STRAFE: begin
						px_q <= sum_x > 33'sh0_7FFF_FFFF ? 32'sh7FFF_FFFF :
							sum_x < -33'sh0_8000_0000 ? 32'sh8000_0000 : sum_x[31:0];
						pz_q <= sum_z > 33'sh0_7FFF_FFFF ? 32'sh7FFF_FFFF :
							sum_z < -33'sh0_8000_0000 ? 32'sh8000_0000 : sum_z[31:0];
					end
					KIND_CLIMB: begin
						py_q <= sum_y > 33'sh0_7FFF_FFFF ? 32'sh7FFF_FFFF :
							sum_y < -33'sh0_8000_0000 ? 32'sh8000_0000 : sum_y[31:0];
					end
					default: begin
						yaw_q <= nyaw > 33'(YAW_FULL) ? 15'd0 :
							nyaw < 0 ? 15'(YAW_FULL) : nyaw[14:0];
						pitch_q <= npit > 33'(PITCH_LIMIT) ? 14'(PITCH_LIMIT) :
							npit < -33'(PITCH_LIMIT) ? -14'(PITCH_LIMIT) : npit[13:0];
					end
				endcase
			end
		end
	end

	assign dxg = acc_q;
	assign dyg = prod_q;
	assign nyaw = 33'($signed({1'b0, yaw_q})) + 33'((dxg + 48'sd8) >>> 4);
	assign npit = 33'(pitch_q) + 33'((dyg + 48'sd8) >>> 4);
	assign sum_x = 33'(px_q) + 33'((acc_q + 48'sd8192) >>> 14);
	assign sum_z = 33'(pz_q) + 33'((prod_q + 48'sd8192) >>> 14);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			kind_q <= s_tuser;
			amt_q <= s_tdata[31:0];
			dx_q <= s_tdata[47:32];
			dy_q <= s_tdata[63:48];
		end
		if (state_q == ST_ROT && c_done) begin
			case (which_q)
				2'd0: begin sp_q <= c_sin; cp_q <= c_cos; end
				2'd1: begin sy_q <= c_sin; cy_q <= c_cos; end
				default: begin sr_q <= c_sin; cr_q <= c_cos; end
			endcase
		end
		case (state_q)
			ST_M0: prod_q <= 48'(mp);
			ST_M1: begin acc_q <= 48'(mp); prod_q <= 48'(mp); end
			ST_M2: prod_q <= 48'(mp);
			ST_M3: begin
				cx_q <= 16'(rnd28);
				prod_q <= 48'(mp);
			end
			ST_M4: begin
				if (kind_q == KIND_STRIDE) begin
					cz_q <= 16'((prod_q + 48'sd8192) >>> 14);
				end else begin
					cx_q <= 16'((48'(mp) + 48'sd8192) >>> 14);
					cz_q <= sy_q;
				end
			end
			ST_M5: acc_q <= 48'(mp);
			ST_M6: prod_q <= 48'(mp);
			default: ;
		endcase
		if (state_q == ST_OUT && (!out_v_q || m_tready)) begin
			out_q <= {3'b0, pitch_q, yaw_q, pz_q, py_q, px_q};
		end
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_M0 |-> !s_tready) else $error("ready while busy");
	a_out_only_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT)) else $error("result without command");
	a_pitch_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pitch_q <= 14'sd5361 && pitch_q >= -14'sd5361) else $error("pitch beyond limit");
endmodule

// ===== test/first_person_camera_pose_top_test.sv =====
`timescale 1ns / 1ps

module first_person_camera_pose_top_test;
	import fpcp_pkg::*;

	localparam int STEPS = 16;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_data;

	first_person_camera_pose_top #(.CORDIC_STEPS(STEPS)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct packed {
		logic signed [13:0] pitch;
		logic [14:0]        yaw;
		logic signed [31:0] pz;
		logic signed [31:0] py;
		logic signed [31:0] px;
	} pose_t;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] amount;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		bit                 typed;
		pose_t              pose;
	} command_row_t;

	longint atan_tbl [24] = '{
		13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2
	};

	longint cam_x, cam_y, cam_z, cam_yaw, cam_pitch, gain_q16, roll_q12;
	pose_t  pose_queue [$];
	int     errors;
	int     send_idle_pct;
	int     recv_stall_pct;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint rnd_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic void sin_cos_q14(input longint ang, output longint s, output longint c);
		longint z, x, y, nx, xs, ys;
		bit flip;
		z = ang * 4096;
		x = longint'(CORDIC_K_Q30);
		y = 0;
		flip = 1'b0;
		if (z > longint'(PI_Q24)) z -= longint'(TWO_PI_Q24);
		else if (z < -longint'(PI_Q24)) z += longint'(TWO_PI_Q24);
		if (z > longint'(HALF_PI_Q24)) begin
			z -= longint'(PI_Q24);
			flip = 1'b1;
		end else if (z < -longint'(HALF_PI_Q24)) begin
			z += longint'(PI_Q24);
			flip = 1'b1;
		end
		for (int i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				nx = x - ys;
				y = y + xs;
				z -= atan_tbl[i];
			end else begin
				nx = x + ys;
				y = y - xs;
				z += atan_tbl[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = rnd_shift(x, 16);
		s = rnd_shift(y, 16);
	endfunction

	function automatic void move_pose(input longint cx, input longint cz, input longint amt);
		cam_x = clip32(cam_x + rnd_shift(cx * amt, 14));
		cam_z = clip32(cam_z + rnd_shift(cz * amt, 14));
	endfunction

	function automatic pose_t next_pose(input kind_t kind, input longint amt,
			input longint dx, input longint dy);
		longint sp, cp, sy, cy, sr, cr, vx, vz, ny, np;
		pose_t p;
		sin_cos_q14(cam_pitch, sp, cp);
		sin_cos_q14(cam_yaw, sy, cy);
		sin_cos_q14(roll_q12, sr, cr);
		case (kind)
			KIND_STRIDE: begin
				vx = rnd_shift(cp * sy * cr - sp * sr * 16384, 28);
				vz = rnd_shift(-cp * cy, 14);
				move_pose(vx, vz, amt);
			end
			KIND_STRAFE: move_pose(rnd_shift(cy * cr, 14), sy, amt);
			KIND_CLIMB: cam_y = clip32(cam_y + amt);
			default: begin
				ny = cam_yaw + rnd_shift(dx * gain_q16, 4);
				np = cam_pitch + rnd_shift(dy * gain_q16, 4);
				if (ny > YAW_FULL) ny = 0;
				else if (ny < 0) ny = YAW_FULL;
				if (np > PITCH_LIMIT) np = PITCH_LIMIT;
				else if (np < -PITCH_LIMIT) np = -PITCH_LIMIT;
				cam_yaw = ny;
				cam_pitch = np;
			end
		endcase
		p.px = cam_x[31:0];
		p.py = cam_y[31:0];
		p.pz = cam_z[31:0];
		p.yaw = cam_yaw[14:0];
		p.pitch = cam_pitch[13:0];
		return p;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[124:0];
			if (pose_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pose_queue.pop_front();
				if (got.px !== want.px) begin
					$display("%0t: pos_x expected %h actual %h", $time, want.px, got.px);
					errors++;
				end
				if (got.py !== want.py) begin
					$display("%0t: pos_y expected %h actual %h", $time, want.py, got.py);
					errors++;
				end
				if (got.pz !== want.pz) begin
					$display("%0t: pos_z expected %h actual %h", $time, want.pz, got.pz);
					errors++;
				end
				if (got.yaw !== want.yaw) begin
					$display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
					errors++;
				end
				if (got.pitch !== want.pitch) begin
					$display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
						got.pitch);
					errors++;
				end
			end
		end
	end

	task automatic send_command(input command_row_t row);
		pose_t p;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= row.kind;
		s_tdata <= {row.dy, row.dx, row.amount};
		do @(posedge clk); while (!s_tready);
		p = next_pose(row.kind, row.amount, row.dx, row.dy);
		pose_queue.push_back(row.typed ? row.pose : p);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (pose_queue.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_LOOK_GAIN) gain_q16 = value;
		else roll_q12 = longint'(signed'(value));
	endtask

	function automatic command_row_t random_command();
		command_row_t r;
		int k;
		k = $urandom_range(99);
		r.kind = k < 35 ? KIND_LOOK : k < 60 ? KIND_STRIDE : k < 85 ? KIND_STRAFE : KIND_CLIMB;
		case ($urandom_range(3))
			0: r.amount = $urandom;
			1: r.amount = $signed($urandom_range(2097152)) - 1048576;
			2: r.amount = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: r.amount = $signed($urandom_range(268435456)) - 134217728;
		endcase
		if ($urandom_range(1)) begin
			r.dx = 16'($urandom);
			r.dy = 16'($urandom);
		end else begin
			r.dx = 16'($signed($urandom_range(400)) - 200);
			r.dy = 16'($signed($urandom_range(400)) - 200);
		end
		r.typed = 1'b0;
		r.pose = '0;
		return r;
	endfunction

	command_row_t directed [] = '{
		'{KIND_CLIMB, 32'sh7fffffff, 16'sd0, 16'sd0, 1'b1,
			'{14'sd0, 15'd0, 32'sd0, 32'sh7fffffff, 32'sd0}},
		'{KIND_CLIMB, 32'sd1, 16'sd0, 16'sd0, 1'b1,
			'{14'sd0, 15'd0, 32'sd0, 32'sh7fffffff, 32'sd0}},
		'{KIND_LOOK, 32'sd0, -16'sd1, 16'sh7fff, 1'b1,
			'{14'sd5361, 15'd25736, 32'sd0, 32'sh7fffffff, 32'sd0}},
		'{KIND_LOOK, 32'sd0, 16'sd1, -16'sh8000, 1'b1,
			'{-14'sd5361, 15'd0, 32'sd0, 32'sh7fffffff, 32'sd0}},
		'{KIND_CLIMB, 32'sh80000000, 16'sd0, 16'sd0, 1'b1,
			'{-14'sd5361, 15'd0, 32'sd0, -32'sd1, 32'sd0}},
		'{KIND_STRIDE, 32'sh7fffffff, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_STRIDE, 32'sh7fffffff, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_STRAFE, 32'sh80000000, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_STRAFE, 32'sh80000000, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_LOOK, 32'sd0, 16'sh7fff, 16'sd300, 1'b0, '0},
		'{KIND_STRIDE, 32'sh00010000, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_STRAFE, -32'sh00010000, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_LOOK, 32'sd0, -16'sh8000, -16'sd77, 1'b0, '0},
		'{KIND_STRIDE, -32'sd1, 16'sh5555, -16'sh5556, 1'b0, '0},
		'{KIND_STRAFE, 32'sd1, -16'sh5556, 16'sh5555, 1'b0, '0},
		'{KIND_LOOK, 32'sh5a5a5a5a, 16'sd1000, 16'sd0, 1'b0, '0},
		'{KIND_STRIDE, 32'sh40000000, 16'sd0, 16'sd0, 1'b0, '0},
		'{KIND_CLIMB, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0}
	};

	initial begin
		int gains [8] = '{20, 65535, 0, 1, 300, 4096, 20, 777};
		int rolls [8] = '{0, 25736, -25736, 32767, -32768, 1234, 0, -4000};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cam_x = 0; cam_y = 0; cam_z = 0; cam_yaw = 0; cam_pitch = 0;
		gain_q16 = 20;
		roll_q12 = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_command(directed[i]);

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_LOOK_GAIN, 16'(gains[ph]));
			write_reg(CFG_ROLL_ANGLE, 16'(rolls[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int n = 0; n < 206; n++) begin
				send_command(random_command());
			end
		end

		drain();
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
